@@ sv/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV converter
// Holds the hue format codes, the hue sector codes and the stage structs.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Channel and divider widths
  localparam int CH_W    = 8;
  localparam int NUM_W   = 16;
  localparam int HUE_W   = 11;
  localparam int DEN_X_W = 9;
  localparam int Q_X_W   = 9;

  // Hue output format, as written to the configuration register
  typedef enum logic [1:0] {
    FMT_RAW  = 2'd0,
    FMT_BYTE = 2'd1,
    FMT_DEG  = 2'd2
  } hue_fmt_t;

  // Six hue sectors; the sector number is the upper bits of the raw hue
  typedef logic [2:0] sector_t;
  localparam sector_t SEC_RED_RISE   = 3'd0;
  localparam sector_t SEC_GRN_FALL   = 3'd1;
  localparam sector_t SEC_GRN_RISE   = 3'd2;
  localparam sector_t SEC_BLU_FALL   = 3'd3;
  localparam sector_t SEC_BLU_RISE   = 3'd4;
  localparam sector_t SEC_RED_FALL   = 3'd5;

  // Sorted channels out of the front stage
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic            grey;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] mid;
    logic [CH_W-1:0] lo;
    sector_t         sector;
    logic            rising;
  } front_t;

  // Side data that travels with the channel scaling divider
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] val;
    sector_t         sector;
    logic            rising;
  } scl_side_t;

  // Side data that travels with the hue fraction divider
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic            grey;
    logic [CH_W-1:0] val;
    sector_t         sector;
    logic            rising;
    logic [CH_W-1:0] sat;
  } xdiv_side_t;

  // One converted color
  typedef struct packed {
    logic [CH_W-1:0]  alpha;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

endpackage

@@ sv/rgbhsv_sort.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_sort: front stage of the RGB to HSV converter
// Splits the color, sorts the channels and picks the hue sector, registered.
// ----------------------------------------------------------------------------
module rgbhsv_sort (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic [31:0]         color_i,
  output logic                valid_o,
  output rgbhsv_pkg::front_t  front_o
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0] r, g, b;
  logic [CH_W-1:0] max_rg, min_rg, hi, lo, mid;
  logic [CH_W+1:0] sum;
  logic            valid_r;
  front_t          front_r, front_nxt;

  assign r = color_i[23:16];
  assign g = color_i[15:8];
  assign b = color_i[7:0];

  // Sort: max and min by compare, middle as what is left of the sum
  assign max_rg = (r > g) ? r : g;
  assign min_rg = (r > g) ? g : r;
  assign hi     = (b > max_rg) ? b : max_rg;
  assign lo     = (b < min_rg) ? b : min_rg;
  assign sum    = (CH_W+2)'(r) + (CH_W+2)'(g) + (CH_W+2)'(b);
  assign mid    = CH_W'(sum - (CH_W+2)'(hi) - (CH_W+2)'(lo));

  // Pick the sector from the largest channel and the middle one
  always_comb begin
    front_nxt       = '0;
    front_nxt.alpha = color_i[31:24];
    front_nxt.grey  = (r == g) && (g == b);
    front_nxt.hi    = hi;
    front_nxt.mid   = mid;
    front_nxt.lo    = lo;
    if (r == hi) begin
      front_nxt.rising = (g == mid);
      front_nxt.sector = (g == mid) ? SEC_RED_RISE : SEC_RED_FALL;
    end else if (g == hi) begin
      front_nxt.rising = (b == mid);
      front_nxt.sector = (b == mid) ? SEC_GRN_RISE : SEC_GRN_FALL;
    end else begin
      front_nxt.rising = (r == mid);
      front_nxt.sector = (r == mid) ? SEC_BLU_RISE : SEC_BLU_FALL;
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    front_r <= front_nxt;
  end

  assign valid_o = valid_r;
  assign front_o = front_r;

endmodule

@@ sv/rgbhsv_div.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_div: pipelined restoring divider
// One quotient bit per stage, QW stages; the numerator must be below
// den << QW. Side data and valid travel alongside the quotient.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = NW + DW + QW;

  logic          v_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic [SW-1:0] s_r   [QW];
  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] d_r   [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Sh = QW - 1 - k;

    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [CW-1:0] trial;
    logic          ge;

    // Take the stage input from the ports or the previous stage
    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign d_in   = den_i;
      assign q_in   = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign d_in   = d_r[k-1];
      assign q_in   = q_r[k-1];
      assign s_in   = s_r[k-1];
    end

    // Trial subtract of the shifted divisor
    assign trial = CW'(d_in) << Sh;
    assign ge    = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      q_r[k] <= q_in | (QW'(ge) << Sh);
      s_r[k] <= s_in;
    end

    // Carry remainder and divisor to the next stage
    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? NW'(CW'(rem_in) - trial) : rem_in;
        d_r[k]   <= d_in;
      end
    end
  end

  assign valid_o = v_r[QW-1];
  assign quo_o   = q_r[QW-1];
  assign side_o  = s_r[QW-1];

endmodule

@@ sv/rgbhsv_fmt.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_fmt: output format stages of the RGB to HSV converter
// First stage forms byte hue, degree hue and percent values by reciprocal
// multiplies; second stage selects by format and registers the result.
// ----------------------------------------------------------------------------
module rgbhsv_fmt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  rgbhsv_pkg::hsv_t      hsv_i,
  input  rgbhsv_pkg::hue_fmt_t  fmt_i,
  output logic                  valid_o,
  output rgbhsv_pkg::hsv_t      hsv_o
);
  import rgbhsv_pkg::*;

  // floor(n / 6) = n * BYTE_RCP >> 16 for n below 32768
  localparam logic [13:0] BYTE_RCP = 14'd10923;
  // floor(n * 359 / 1530) = n * DEG_RCP >> 22 for n below 8192
  localparam logic [19:0] DEG_RCP  = 20'd984154;
  // floor(n * 100 / 255) = n * PCT_RCP >> 16 for n up to 255
  localparam logic [14:0] PCT_RCP  = 15'd25701;

  logic [HUE_W-1:0] hue_n;
  logic [24:0]      prod_byte;
  logic [30:0]      prod_deg;
  logic [22:0]      prod_sat, prod_val;

  logic             d_v_r;
  hsv_t             d_hsv_r;
  logic [7:0]       d_byte_r;
  logic [8:0]       d_deg_r;
  logic [6:0]       d_sat_pct_r, d_val_pct_r;

  logic             e_v_r;
  hsv_t             e_hsv_r, e_hsv_nxt;

  // Rounded hue index and the reciprocal products
  assign hue_n     = hsv_i.hue + HUE_W'(3);
  assign prod_byte = 25'(hue_n) * 25'(BYTE_RCP);
  assign prod_deg  = 31'(hue_n) * 31'(DEG_RCP);
  assign prod_sat  = 23'(hsv_i.sat) * 23'(PCT_RCP);
  assign prod_val  = 23'(hsv_i.val) * 23'(PCT_RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      d_v_r <= valid_i;
      e_v_r <= d_v_r;
    end
  end

  // Hold products; byte hue keeps the low 8 bits so 256 wraps to 0
  always_ff @(posedge clk) begin
    d_hsv_r     <= hsv_i;
    d_byte_r    <= prod_byte[23:16];
    d_deg_r     <= prod_deg[30:22];
    d_sat_pct_r <= prod_sat[22:16];
    d_val_pct_r <= prod_val[22:16];
  end

  // Select the configured format
  always_comb begin
    e_hsv_nxt = d_hsv_r;
    case (fmt_i)
      FMT_RAW: begin
        e_hsv_nxt = d_hsv_r;
      end
      FMT_BYTE: begin
        e_hsv_nxt.hue = HUE_W'(d_byte_r);
      end
      FMT_DEG: begin
        e_hsv_nxt.hue = HUE_W'(d_deg_r);
        e_hsv_nxt.sat = CH_W'(d_sat_pct_r);
        e_hsv_nxt.val = CH_W'(d_val_pct_r);
      end
      default: begin
        e_hsv_nxt = d_hsv_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    e_hsv_r <= e_hsv_nxt;
  end

  assign valid_o = e_v_r;
  assign hsv_o   = e_hsv_r;

endmodule

@@ sv/rgb_to_hsv_convert_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core: ARGB to HSV converter, six-sector integer hue
// Path: sort register, channel scaling dividers, operand register,
// hue fraction divider, hue register and the format stages, in order.
// Throughput: one color per cycle; busy stays low, set by the fully
// pipelined dividers (8 stages for channel scaling, 9 for the hue fraction).
// Reset clears every valid bit and sets the hue format to raw.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_argb_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_hue_format,
  output logic        out_valid,
  output logic [7:0]  out_alpha_out,
  output logic [10:0] out_hue_out,
  output logic [7:0]  out_saturation_out,
  output logic [7:0]  out_value_out
);
  import rgbhsv_pkg::*;

  localparam int LAT = 22;

  hue_fmt_t          hue_fmt_r;

  logic              front_v;
  front_t            front;
  logic [NUM_W-1:0]  num_mid, num_lo;
  scl_side_t         sa_side;
  logic              sa_v, sl_v, sl_grey;
  logic [CH_W-1:0]   mid_s, lo_s;
  logic [$bits(scl_side_t)-1:0] sa_side_vec;
  scl_side_t         sa_side_out;

  logic              b_v_r;
  xdiv_side_t        b_side_r, b_side_nxt;
  logic [NUM_W-1:0]  b_num_r, b_num_nxt;
  logic [DEN_X_W-1:0] b_den_r, b_den_nxt;
  logic [CH_W-1:0]   sat_b, diff_b;

  logic              x_v;
  logic [Q_X_W-1:0]  x_q;
  logic [$bits(xdiv_side_t)-1:0] x_side_vec;
  xdiv_side_t        x_side;
  logic [CH_W-1:0]   fall;

  logic              c_v_r;
  hsv_t              c_hsv_r, c_hsv_nxt;

  logic              f_v;
  hsv_t              f_hsv;

  // Input and configuration handshakes
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_fmt_r <= FMT_RAW;
    end else if (cfg_valid && cfg_ready) begin
      hue_fmt_r <= hue_fmt_t'(cfg_hue_format);
    end
  end

  // Sort channels
  rgbhsv_sort u_sort (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .color_i (in_argb_color),
    .valid_o (front_v),
    .front_o (front)
  );

  // Scale middle and least channel to 255 * c / max
  assign num_mid = {front.mid, CH_W'(0)} - NUM_W'(front.mid);
  assign num_lo  = {front.lo, CH_W'(0)} - NUM_W'(front.lo);

  always_comb begin
    sa_side        = '0;
    sa_side.alpha  = front.alpha;
    sa_side.val    = front.hi;
    sa_side.sector = front.sector;
    sa_side.rising = front.rising;
  end

  rgbhsv_div #(
    .NW (NUM_W),
    .DW (CH_W),
    .QW (CH_W),
    .SW ($bits(scl_side_t))
  ) u_div_mid (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_v),
    .num_i   (num_mid),
    .den_i   (front.hi),
    .side_i  (sa_side),
    .valid_o (sa_v),
    .quo_o   (mid_s),
    .side_o  (sa_side_vec)
  );

  rgbhsv_div #(
    .NW (NUM_W),
    .DW (CH_W),
    .QW (CH_W),
    .SW (1)
  ) u_div_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (front_v),
    .num_i   (num_lo),
    .den_i   (front.hi),
    .side_i  (front.grey),
    .valid_o (sl_v),
    .quo_o   (lo_s),
    .side_o  (sl_grey)
  );

  assign sa_side_out = scl_side_t'(sa_side_vec);

  // Saturation and fraction operands
  assign sat_b  = CH_W'(255) - lo_s;
  assign diff_b = mid_s - lo_s;

  always_comb begin
    b_side_nxt        = '0;
    b_side_nxt.alpha  = sa_side_out.alpha;
    b_side_nxt.grey   = sl_grey;
    b_side_nxt.val    = sa_side_out.val;
    b_side_nxt.sector = sa_side_out.sector;
    b_side_nxt.rising = sa_side_out.rising;
    b_side_nxt.sat    = sat_b;
    b_num_nxt         = {diff_b, CH_W'(0)};
    b_den_nxt         = DEN_X_W'(sat_b) + DEN_X_W'(sat_b[CH_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= sa_v && sl_v;
    end
  end

  always_ff @(posedge clk) begin
    b_side_r <= b_side_nxt;
    b_num_r  <= b_num_nxt;
    b_den_r  <= b_den_nxt;
  end

  // Hue fraction ((mid - lo) << 8) / (sat + sat / 128)
  rgbhsv_div #(
    .NW (NUM_W),
    .DW (DEN_X_W),
    .QW (Q_X_W),
    .SW ($bits(xdiv_side_t))
  ) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (b_v_r),
    .num_i   (b_num_r),
    .den_i   (b_den_r),
    .side_i  (b_side_r),
    .valid_o (x_v),
    .quo_o   (x_q),
    .side_o  (x_side_vec)
  );

  assign x_side = xdiv_side_t'(x_side_vec);

  // Falling sectors use 255 - x, clamped at 0 when x reaches 256
  assign fall = x_q[Q_X_W-1] ? CH_W'(0) : (CH_W'(255) - x_q[CH_W-1:0]);

  // Assemble raw hue; grey forces hue and saturation to 0
  always_comb begin
    c_hsv_nxt       = '0;
    c_hsv_nxt.alpha = x_side.alpha;
    c_hsv_nxt.val   = x_side.val;
    if (!x_side.grey) begin
      c_hsv_nxt.sat = x_side.sat;
      c_hsv_nxt.hue = {x_side.sector, CH_W'(0)} +
                      (x_side.rising ? HUE_W'(x_q) : HUE_W'(fall));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= x_v;
    end
  end

  always_ff @(posedge clk) begin
    c_hsv_r <= c_hsv_nxt;
  end

  // Format and output register
  rgbhsv_fmt u_fmt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (c_v_r),
    .hsv_i   (c_hsv_r),
    .fmt_i   (hue_fmt_r),
    .valid_o (f_v),
    .hsv_o   (f_hsv)
  );

  assign out_valid          = f_v;
  assign out_alpha_out      = f_hsv.alpha;
  assign out_hue_out        = f_hsv.hue;
  assign out_saturation_out = f_hsv.sat;
  assign out_value_out      = f_hsv.val;

  // Every result strobe goes back to an earlier input transfer
  a_out_has_source : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching input transfer");

  // Grey colors come out with zero hue and saturation in every format
  a_grey_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_argb_color[23:16] == in_argb_color[15:8] &&
     in_argb_color[15:8] == in_argb_color[7:0])
    |-> ##LAT (out_valid && out_hue_out == 11'd0 && out_saturation_out == 8'd0))
    else $error("grey color gave nonzero hue or saturation");

  // Alpha passes through unchanged
  a_alpha_pass : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT (out_alpha_out == $past(in_argb_color[31:24], LAT)))
    else $error("alpha changed through the pipeline");

  // Hue never leaves the raw range
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_out <= 11'd1535))
    else $error("hue out of range");

endmodule
